FILE: hw/rtl/zlhd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// zlhd_pkg
// Types and constants of the archive local header deframer.
// ----------------------------------------------------------------------------
package zlhd_pkg;

    // walk phase
    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_NAME    = 3'd1,
        PH_EXTRA   = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_SKIP    = 3'd4,
        PH_STOPPED = 3'd5
    } t_phase;

    // local header layout
    localparam int unsigned HEADER_BYTES = 30;
    localparam logic [4:0]  HDR_SIG0      = 5'd0;
    localparam logic [4:0]  HDR_SIG1      = 5'd1;
    localparam logic [4:0]  HDR_METHOD_LO = 5'd8;
    localparam logic [4:0]  HDR_METHOD_HI = 5'd9;
    localparam logic [4:0]  HDR_SIZE_B0   = 5'd18;
    localparam logic [4:0]  HDR_SIZE_B1   = 5'd19;
    localparam logic [4:0]  HDR_SIZE_B2   = 5'd20;
    localparam logic [4:0]  HDR_SIZE_B3   = 5'd21;
    localparam logic [4:0]  HDR_NAME_LO   = 5'd26;
    localparam logic [4:0]  HDR_NAME_HI   = 5'd27;
    localparam logic [4:0]  HDR_EXTRA_LO  = 5'd28;
    localparam logic [4:0]  HDR_LAST      = 5'(HEADER_BYTES - 1);

    // signature bytes
    localparam logic [7:0] SIG_P = 8'h50;
    localparam logic [7:0] SIG_K = 8'h4B;

    // compression methods
    localparam logic [15:0] METHOD_STORED  = 16'd0;
    localparam logic [15:0] METHOD_DEFLATE = 16'd8;

    // result kinds
    localparam logic [1:0] KIND_START   = 2'd0;
    localparam logic [1:0] KIND_NAME    = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD = 2'd2;
    localparam logic [1:0] KIND_STOP    = 2'd3;

    // stop reasons
    localparam logic [1:0] STOP_BAD_SIG    = 2'd0;
    localparam logic [1:0] STOP_OVERRUN    = 2'd1;
    localparam logic [1:0] STOP_SHORT_TAIL = 2'd2;
    localparam logic [1:0] STOP_NONE       = 2'd0;

    localparam logic [15:0] ENTRY_MAX = 16'hFFFF;

endpackage
`default_nettype wire

FILE: hw/rtl/zip_local_header_deframer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// zip_local_header_deframer
// Walks archive local file headers and forwards entry names and payloads.
// ----------------------------------------------------------------------------
// One archive byte is taken per cycle unless the result side stalls, and its
// result is registered; the only storage between the two sides is the result
// register, so a new byte is taken whenever the result register is empty or is
// being drained. Write the archive length over the config channel before the
// first byte. Each 30-byte local header is checked for its signature and for
// fitting within the archive; stored and deflate entries give an entry start,
// their name bytes and payload bytes (the final byte of each marked as last);
// other methods are dropped quietly. A stop report ends the walk, and all
// bytes after it are dropped until reset.
module zip_local_header_deframer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // config write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [31:0] i_archive_length,
    // archive byte channel
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_archive_byte,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_byte_value,
    output logic [15:0]      o_entry_number,
    output logic             o_is_deflated,
    output logic             o_last_of_part,
    output logic [1:0]       o_stop_reason
);
    import zlhd_pkg::*;

    // first non-empty part at or after the given one, header if none
    function automatic t_phase pick_part(input t_phase from, input logic [15:0] nlen,
                                         input logic [15:0] elen,
                                         input logic [31:0] plen);
        t_phase ph;
        if (from <= PH_NAME && nlen != 16'd0) begin
            ph = PH_NAME;
        end else if (from <= PH_EXTRA && elen != 16'd0) begin
            ph = PH_EXTRA;
        end else if (plen != 32'd0) begin
            ph = PH_PAYLOAD;
        end else begin
            ph = PH_HEADER;
        end
        return ph;
    endfunction

    // registers
    t_phase      r_phase, n_phase;
    logic [4:0]  r_hdr_cnt, n_hdr_cnt;
    logic [31:0] r_pos, n_pos;
    logic [15:0] r_method, n_method;
    logic [31:0] r_size, n_size;
    logic [15:0] r_name, n_name;
    logic [15:0] r_extra, n_extra;
    logic [31:0] r_part, n_part;
    logic [15:0] r_entry, n_entry;
    logic [33:0] r_bound_base, n_bound_base;
    logic [32:0] r_skip_base, n_skip_base;
    logic [31:0] r_len;

    logic        r_out_valid;
    logic [1:0]  r_kind;
    logic [7:0]  r_byte;
    logic [15:0] r_entry_out;
    logic        r_defl;
    logic        r_last;
    logic [1:0]  r_reason;

    // shared decode
    logic        take;
    logic [15:0] extra_full;
    logic [33:0] bound_end;
    logic        tail_short;
    logic        bad_sig;
    logic        too_long;
    logic        method_ok;
    logic        is_defl;
    logic [31:0] skip_len;
    logic        part_zero;
    logic        part_last;
    t_phase      hdr_pick;

    // result of this request
    logic        emit;
    logic [1:0]  res_kind;
    logic [7:0]  res_byte;
    logic        res_defl;
    logic        res_last;
    logic [1:0]  res_reason;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign take        = i_in_valid && o_in_ready;

    assign extra_full = {i_archive_byte, r_extra[7:0]};
    assign bound_end  = r_bound_base + {18'd0, extra_full};
    assign tail_short = ({1'b0, r_pos} + 33'(HEADER_BYTES)) > {1'b0, r_len};
    assign bad_sig    = (r_hdr_cnt == HDR_SIG0 && i_archive_byte != SIG_P)
                     || (r_hdr_cnt == HDR_SIG1 && i_archive_byte != SIG_K);
    assign too_long   = bound_end > {2'b00, r_len};
    assign method_ok  = (r_method == METHOD_STORED) || (r_method == METHOD_DEFLATE);
    assign is_defl    = (r_method == METHOD_DEFLATE);
    assign skip_len   = 32'(r_skip_base + {17'd0, extra_full});
    assign part_zero  = (r_part == 32'd0);
    assign part_last  = (r_part == 32'd1);
    assign hdr_pick   = pick_part(PH_NAME, r_name, extra_full, r_size);

    // next state
    always_comb begin
        n_phase      = r_phase;
        n_hdr_cnt    = r_hdr_cnt;
        n_pos        = r_pos;
        n_method     = r_method;
        n_size       = r_size;
        n_name       = r_name;
        n_extra      = r_extra;
        n_part       = r_part;
        n_entry      = r_entry;
        n_bound_base = r_bound_base;
        n_skip_base  = r_skip_base;
        if (take) begin
            case (r_phase)
                PH_HEADER: begin
                    if (r_hdr_cnt == HDR_SIG0 && tail_short) begin
                        n_phase = PH_STOPPED;
                    end else if (bad_sig) begin
                        n_phase = PH_STOPPED;
                    end else begin
                        n_pos = r_pos + 32'd1;
                        // field capture
                        case (r_hdr_cnt)
                            HDR_METHOD_LO: n_method = {8'd0, i_archive_byte};
                            HDR_METHOD_HI: n_method[15:8] = i_archive_byte;
                            HDR_SIZE_B0:   n_size = {24'd0, i_archive_byte};
                            HDR_SIZE_B1:   n_size[15:8] = i_archive_byte;
                            HDR_SIZE_B2:   n_size[23:16] = i_archive_byte;
                            HDR_SIZE_B3:   n_size[31:24] = i_archive_byte;
                            HDR_NAME_LO:   n_name = {8'd0, i_archive_byte};
                            HDR_NAME_HI:   n_name[15:8] = i_archive_byte;
                            HDR_EXTRA_LO: begin
                                n_extra      = {8'd0, i_archive_byte};
                                // entry end less the extra field, position of byte 30
                                n_bound_base = {2'b00, r_pos} + 34'd2 + {2'b00, r_size}
                                             + {18'd0, r_name};
                                n_skip_base  = {1'b0, r_size} + {17'd0, r_name};
                            end
                            HDR_LAST:      n_extra = extra_full;
                            default: ;
                        endcase
                        if (r_hdr_cnt != HDR_LAST) begin
                            n_hdr_cnt = r_hdr_cnt + 5'd1;
                        end else begin
                            n_hdr_cnt = HDR_SIG0;
                            if (too_long) begin
                                n_phase = PH_STOPPED;
                            end else if (method_ok) begin
                                n_phase = hdr_pick;
                                case (hdr_pick)
                                    PH_NAME:    n_part = {16'd0, r_name};
                                    PH_EXTRA:   n_part = {16'd0, extra_full};
                                    PH_PAYLOAD: n_part = r_size;
                                    default: begin
                                        if (r_entry != ENTRY_MAX) n_entry = r_entry + 16'd1;
                                    end
                                endcase
                            end else if (skip_len == 32'd0) begin
                                if (r_entry != ENTRY_MAX) n_entry = r_entry + 16'd1;
                            end else begin
                                n_phase = PH_SKIP;
                                n_part  = skip_len;
                            end
                        end
                    end
                end
                PH_NAME, PH_EXTRA, PH_PAYLOAD, PH_SKIP: begin
                    n_pos = r_pos + 32'd1;
                    if (part_zero) begin
                        // not reachable; fall back to a header
                        n_phase   = PH_HEADER;
                        n_hdr_cnt = HDR_SIG0;
                        if (r_entry != ENTRY_MAX) n_entry = r_entry + 16'd1;
                    end else begin
                        n_part = r_part - 32'd1;
                        if (part_last) begin
                            case (r_phase)
                                PH_NAME:  n_phase = pick_part(PH_EXTRA, r_name, r_extra, r_size);
                                PH_EXTRA: n_phase = pick_part(PH_PAYLOAD, r_name, r_extra,
                                                              r_size);
                                default:  n_phase = PH_HEADER;
                            endcase
                            case (n_phase)
                                PH_EXTRA:   n_part = {16'd0, r_extra};
                                PH_PAYLOAD: n_part = r_size;
                                default: begin
                                    n_hdr_cnt = HDR_SIG0;
                                    if (r_entry != ENTRY_MAX) n_entry = r_entry + 16'd1;
                                end
                            endcase
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // result of the current request
    always_comb begin
        emit       = 1'b0;
        res_kind   = KIND_START;
        res_byte   = 8'd0;
        res_defl   = 1'b0;
        res_last   = 1'b0;
        res_reason = STOP_NONE;
        case (r_phase)
            PH_HEADER: begin
                if (r_hdr_cnt == HDR_SIG0 && tail_short) begin
                    emit       = 1'b1;
                    res_kind   = KIND_STOP;
                    res_reason = STOP_SHORT_TAIL;
                end else if (bad_sig) begin
                    emit       = 1'b1;
                    res_kind   = KIND_STOP;
                    res_reason = STOP_BAD_SIG;
                end else if (r_hdr_cnt == HDR_LAST) begin
                    if (too_long) begin
                        emit       = 1'b1;
                        res_kind   = KIND_STOP;
                        res_reason = STOP_OVERRUN;
                    end else if (method_ok) begin
                        emit     = 1'b1;
                        res_kind = KIND_START;
                        res_defl = is_defl;
                    end
                end
            end
            PH_NAME: begin
                emit     = !part_zero;
                res_kind = KIND_NAME;
                res_byte = i_archive_byte;
                res_defl = is_defl;
                res_last = part_last;
            end
            PH_PAYLOAD: begin
                emit     = !part_zero;
                res_kind = KIND_PAYLOAD;
                res_byte = i_archive_byte;
                res_defl = is_defl;
                res_last = part_last;
            end
            default: ;
        endcase
    end

    // walk state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HEADER;
            r_hdr_cnt    <= HDR_SIG0;
            r_pos        <= 32'd0;
            r_method     <= 16'd0;
            r_size       <= 32'd0;
            r_name       <= 16'd0;
            r_extra      <= 16'd0;
            r_part       <= 32'd0;
            r_entry      <= 16'd0;
            r_bound_base <= 34'd0;
            r_skip_base  <= 33'd0;
        end else begin
            r_phase      <= n_phase;
            r_hdr_cnt    <= n_hdr_cnt;
            r_pos        <= n_pos;
            r_method     <= n_method;
            r_size       <= n_size;
            r_name       <= n_name;
            r_extra      <= n_extra;
            r_part       <= n_part;
            r_entry      <= n_entry;
            r_bound_base <= n_bound_base;
            r_skip_base  <= n_skip_base;
        end
    end

    // archive length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= 32'd0;
        end else if (i_cfg_valid) begin
            r_len <= i_archive_length;
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (take && emit) begin
            r_kind      <= res_kind;
            r_byte      <= res_byte;
            r_entry_out <= r_entry;
            r_defl      <= res_defl;
            r_last      <= res_last;
            r_reason    <= res_reason;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_kind;
    assign o_byte_value   = r_byte;
    assign o_entry_number = r_entry_out;
    assign o_is_deflated  = r_defl;
    assign o_last_of_part = r_last;
    assign o_stop_reason  = r_reason;

endmodule
`default_nettype wire
